// ===== rtl/s5rc_pkg.sv =====
// shared types and constants for the socks5 reply checker
package s5rc_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned StatusW    = 4;
  localparam int unsigned PhaseW     = 4;
  localparam int unsigned CountW     = 9;

  localparam logic [ByteW-1:0]  SocksVersion = 8'd5;
  localparam logic [ByteW-1:0]  MethodNoAuth = 8'd0;
  localparam logic [ByteW-1:0]  MethodUser   = 8'd2;
  localparam logic [ByteW-1:0]  AtypIpv4     = 8'h01;
  localparam logic [ByteW-1:0]  AtypDomain   = 8'h03;
  localparam logic [ByteW-1:0]  AtypIpv6     = 8'h04;
  localparam logic [CountW-1:0] Ipv4Len      = 9'd4;
  localparam logic [CountW-1:0] Ipv6Len      = 9'd16;
  localparam logic [CountW-1:0] PortLen      = 9'd2;

  localparam logic FuncStart = 1'b0;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE       = 4'd0,
    PH_HELLO_VER  = 4'd1,
    PH_HELLO_METH = 4'd2,
    PH_AUTH_VER   = 4'd3,
    PH_AUTH_STAT  = 4'd4,
    PH_REP_VER    = 4'd5,
    PH_REP_CODE   = 4'd6,
    PH_REP_RSV    = 4'd7,
    PH_REP_ATYP   = 4'd8,
    PH_DOM_LEN    = 4'd9,
    PH_ADDR       = 4'd10,
    PH_FINISHED   = 4'd11
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_BUSY       = 4'd0,
    ST_SEND_AUTH  = 4'd1,
    ST_SEND_CONN  = 4'd2,
    ST_DONE       = 4'd3,
    ST_BAD_VER    = 4'd4,
    ST_BAD_METHOD = 4'd5,
    ST_AUTH_FAIL  = 4'd6,
    ST_REPLY_ERR  = 4'd7,
    ST_BAD_ATYP   = 4'd8
  } status_e;

endpackage

// ===== rtl/s5rc_if.sv =====
// item channel interfaces for the socks5 reply checker
interface s5rc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface s5rc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [7:0] reply_code;

  modport source (output valid, output status, output reply_code, input ready);
  modport sink   (input valid, input status, input reply_code, output ready);
endinterface

// ===== rtl/socks5_reply_checker.sv =====
// socks5 client handshake reply checker, top level
//
// usage
// - in_i carries one item per start or received byte: func 0 starts a new
//   handshake, func 1 delivers one byte received from the proxy in rx_byte
// - out_o returns exactly one item per input item: status tells the host
//   what to send next (auth or connect request), that the handshake is
//   done, or why it failed; reply_code carries the failing server code
// - timing: an input item passes the input register, then the result
//   register, before its result is offered on out_o; throughput is one
//   item per cycle while out_o does not stall, set by the combinational
//   phase update between those two registers
// - the input side keeps accepting while a result waits, as long as the
//   input register is empty or can move into a free or draining result register
// - when out_o stalls, both registers hold and in_i.ready drops once the
//   input register is full; nothing is lost or repeated
// - reset: pipeline empties, phase goes idle and bytes until a start item
//   are ignored (status busy, reply_code 0)
// - after done or an error, bytes are ignored until the next start item
module socks5_reply_checker
  import s5rc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  s5rc_in_if.sink    in_i,
  s5rc_out_if.source out_o
);

  // input register
  logic             s1_valid_q;
  logic             s1_func_q;
  logic [ByteW-1:0] s1_byte_q;

  // handshake tracking state
  phase_e            phase_q, phase_d;
  logic [CountW-1:0] bytes_left_q, bytes_left_d;

  // result register
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [ByteW-1:0]  code_q, code_d;

  logic s1_advance;
  logic in_fire;
  logic [CountW-1:0] left_dec;

  // the input register moves on whenever the result register is free or draining
  assign s1_advance = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q <= in_i.func;
      s1_byte_q <= in_i.rx_byte;
    end
  end

  // saturating countdown of address and port bytes
  assign left_dec = (bytes_left_q != '0) ? bytes_left_q - CountW'(1) : bytes_left_q;

  // phase update and result for the item in the input register
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    status_d     = ST_BUSY;
    code_d       = '0;
    if (s1_func_q == FuncStart) begin
      phase_d      = PH_HELLO_VER;
      bytes_left_d = '0;
    end else begin
      unique case (phase_q)
        PH_HELLO_VER: begin
          if (s1_byte_q == SocksVersion) begin
            phase_d = PH_HELLO_METH;
          end else begin
            status_d = ST_BAD_VER;
            phase_d  = PH_FINISHED;
          end
        end
        PH_HELLO_METH: begin
          if (s1_byte_q == MethodNoAuth) begin
            status_d = ST_SEND_CONN;
            phase_d  = PH_REP_VER;
          end else if (s1_byte_q == MethodUser) begin
            status_d = ST_SEND_AUTH;
            phase_d  = PH_AUTH_VER;
          end else begin
            status_d = ST_BAD_METHOD;
            phase_d  = PH_FINISHED;
          end
        end
        // auth sub-negotiation version is not checked
        PH_AUTH_VER: begin
          phase_d = PH_AUTH_STAT;
        end
        PH_AUTH_STAT: begin
          if (s1_byte_q == '0) begin
            status_d = ST_SEND_CONN;
            phase_d  = PH_REP_VER;
          end else begin
            status_d = ST_AUTH_FAIL;
            code_d   = s1_byte_q;
            phase_d  = PH_FINISHED;
          end
        end
        PH_REP_VER: begin
          if (s1_byte_q == SocksVersion) begin
            phase_d = PH_REP_CODE;
          end else begin
            status_d = ST_BAD_VER;
            phase_d  = PH_FINISHED;
          end
        end
        PH_REP_CODE: begin
          if (s1_byte_q == '0) begin
            phase_d = PH_REP_RSV;
          end else begin
            status_d = ST_REPLY_ERR;
            code_d   = s1_byte_q;
            phase_d  = PH_FINISHED;
          end
        end
        PH_REP_RSV: begin
          phase_d = PH_REP_ATYP;
        end
        PH_REP_ATYP: begin
          if (s1_byte_q == AtypIpv4) begin
            bytes_left_d = Ipv4Len + PortLen;
            phase_d      = PH_ADDR;
          end else if (s1_byte_q == AtypIpv6) begin
            bytes_left_d = Ipv6Len + PortLen;
            phase_d      = PH_ADDR;
          end else if (s1_byte_q == AtypDomain) begin
            phase_d = PH_DOM_LEN;
          end else begin
            status_d = ST_BAD_ATYP;
            phase_d  = PH_FINISHED;
          end
        end
        // domain length, a zero length leaves just the port bytes
        PH_DOM_LEN: begin
          bytes_left_d = CountW'(s1_byte_q) + PortLen;
          phase_d      = PH_ADDR;
        end
        PH_ADDR: begin
          bytes_left_d = left_dec;
          if (left_dec == '0) begin
            status_d = ST_DONE;
            phase_d  = PH_FINISHED;
          end
        end
        // idle and finished: byte ignored
        default: begin
        end
      endcase
    end
  end

  // state and result commit only when the input register item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bytes_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        phase_q      <= phase_d;
        bytes_left_q <= bytes_left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      status_q <= status_d;
      code_q   <= code_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.reply_code = code_q;

  // a nonzero reply code only comes with an auth failure or a reply error
  a_code_only_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (code_q != '0) |-> (status_q == ST_AUTH_FAIL) || (status_q == ST_REPLY_ERR))
    else $error("reply code set without an error status");

  // the address phase always has bytes outstanding
  a_addr_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ADDR) |-> (bytes_left_q != '0))
    else $error("address phase with no bytes left");

  // the byte counter is only nonzero while collecting address bytes
  a_count_in_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_left_q != '0) |-> (phase_q == PH_ADDR))
    else $error("byte counter live outside address phase");

  // a stalled input register keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_advance |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_func_q))
    else $error("input register item lost under stall");

  // a start item always yields busy with no code
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_advance && (s1_func_q == FuncStart)
      |=> out_valid_q && (status_q == ST_BUSY) && (code_q == '0) && (phase_q == PH_HELLO_VER))
    else $error("start item did not restart the handshake");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the socks5 reply checker
`timescale 1ns / 100ps

module testbench
  import s5rc_pkg::*;
;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned ResetCycles = 10;
  // random part stops once this many bytes that the checker acts on are queued
  localparam int unsigned RandomBytes = 880;
  // two pipeline registers, so this drain is long enough to catch stray items
  localparam int unsigned DrainCycles = 10;
  // cycles with no transfer on either side before the run is failed as hung
  localparam int unsigned StallLimit  = 2000;

  // the byte value that is not a start
  localparam logic FuncByte = ~FuncStart;

  // one input item and one result item
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } hs_byte_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] code;
  } reply_t;

  // where a random handshake goes wrong, if at all
  typedef enum int unsigned {
    F_NONE, F_HELLO_VER, F_METHOD, F_AUTH, F_REP_VER, F_REP_CODE, F_ATYP, F_CUT
  } fault_e;

  // receiver ready patterns
  typedef enum int unsigned {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BEAT} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  s5rc_in_if  in_if ();
  s5rc_out_if out_if ();

  socks5_reply_checker u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(ClkHalf) clk = ~clk;

  hs_byte_t    pending_bytes[$];     // bytes still to be sent
  reply_t      expected_replies[$];  // predicted replies, oldest first
  bit          in_fire;              // input item taken at the last rising edge
  bit          run_failed;
  int unsigned idle_cycles;

  // handshake position as the checker should see it
  phase_e       hs_phase  = PH_IDLE;
  logic [8:0]   addr_left = '0;

  // sender burst/gap bookkeeping
  int unsigned burst_left;
  int unsigned gap_left;

  // receiver pattern bookkeeping
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned stretch_left;
  logic [7:0]  rx_tick = '0;

  function automatic hs_byte_t data_byte(input logic [7:0] b);
    return '{func: FuncByte, rx_byte: b};
  endfunction

  // the rx_byte of a start carries junk, the checker must not look at it
  function automatic hs_byte_t start_item();
    return '{func: FuncStart, rx_byte: 8'($urandom)};
  endfunction

  // advance the handshake by one item and return the reply it causes
  function automatic reply_t predict_reply(input hs_byte_t it);
    reply_t r;
    r.status = ST_BUSY;
    r.code   = '0;
    if (it.func == FuncStart) begin
      // a start wins over whatever phase we were in
      hs_phase  = PH_HELLO_VER;
      addr_left = '0;
    end else begin
      case (hs_phase)
        PH_HELLO_VER: begin
          if (it.rx_byte == SocksVersion) begin
            hs_phase = PH_HELLO_METH;
          end else begin
            r.status = ST_BAD_VER;
            hs_phase = PH_FINISHED;
          end
        end
        PH_HELLO_METH: begin
          if (it.rx_byte == MethodNoAuth) begin
            r.status = ST_SEND_CONN;
            hs_phase = PH_REP_VER;
          end else if (it.rx_byte == MethodUser) begin
            r.status = ST_SEND_AUTH;
            hs_phase = PH_AUTH_VER;
          end else begin
            r.status = ST_BAD_METHOD;
            hs_phase = PH_FINISHED;
          end
        end
        // auth version is taken as is
        PH_AUTH_VER: hs_phase = PH_AUTH_STAT;
        PH_AUTH_STAT: begin
          if (it.rx_byte == '0) begin
            r.status = ST_SEND_CONN;
            hs_phase = PH_REP_VER;
          end else begin
            r.status = ST_AUTH_FAIL;
            r.code   = it.rx_byte;
            hs_phase = PH_FINISHED;
          end
        end
        PH_REP_VER: begin
          if (it.rx_byte == SocksVersion) begin
            hs_phase = PH_REP_CODE;
          end else begin
            r.status = ST_BAD_VER;
            hs_phase = PH_FINISHED;
          end
        end
        PH_REP_CODE: begin
          if (it.rx_byte == '0) begin
            hs_phase = PH_REP_RSV;
          end else begin
            r.status = ST_REPLY_ERR;
            r.code   = it.rx_byte;
            hs_phase = PH_FINISHED;
          end
        end
        PH_REP_RSV: hs_phase = PH_REP_ATYP;
        PH_REP_ATYP: begin
          if (it.rx_byte == AtypIpv4) begin
            addr_left = Ipv4Len + PortLen;
            hs_phase  = PH_ADDR;
          end else if (it.rx_byte == AtypIpv6) begin
            addr_left = Ipv6Len + PortLen;
            hs_phase  = PH_ADDR;
          end else if (it.rx_byte == AtypDomain) begin
            hs_phase = PH_DOM_LEN;
          end else begin
            r.status = ST_BAD_ATYP;
            hs_phase = PH_FINISHED;
          end
        end
        // domain length of zero leaves just the port bytes
        PH_DOM_LEN: begin
          addr_left = {1'b0, it.rx_byte} + PortLen;
          hs_phase  = PH_ADDR;
        end
        PH_ADDR: begin
          if (addr_left != '0) addr_left = addr_left - 9'd1;
          if (addr_left == '0) begin
            r.status = ST_DONE;
            hs_phase = PH_FINISHED;
          end
        end
        // idle and finished ignore bytes
        default: ;
      endcase
    end
    return r;
  endfunction

  // sender: bursts of random length, random gaps, junk payload while idle
  always @(negedge clk) begin : driver_proc
    hs_byte_t nxt;
    if (rst_n && (!in_if.valid || in_fire)) begin
      if (burst_left == 0 && gap_left == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          // long stretch with no idling
          burst_left = $urandom_range(100, 300);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (gap_left != 0) begin
        gap_left--;
        in_if.valid   <= 1'b0;
        in_if.func    <= 1'($urandom_range(0, 1));
        in_if.rx_byte <= 8'($urandom);
      end else if (pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        burst_left--;
        in_if.valid   <= 1'b1;
        in_if.func    <= nxt.func;
        in_if.rx_byte <= nxt.rx_byte;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: ready follows one of a few patterns, each held for a while
  always @(negedge clk) begin : sink_proc
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        stretch_left = $urandom_range(16, 160);
      end else begin
        stretch_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:   out_if.ready <= rx_tick[2];
      endcase
    end
  end

  // predict on every accepted input, check every accepted result, watch for hangs
  always @(posedge clk) begin : monitor_proc
    reply_t want;
    in_fire <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        expected_replies.push_back(predict_reply(hs_byte_t'({in_if.func, in_if.rx_byte})));
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with none expected, status %0d code 0x%02h",
                   $time, out_if.status, out_if.reply_code);
          run_failed = 1'b1;
        end else begin
          want = expected_replies.pop_front();
          if (out_if.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_if.status);
            run_failed = 1'b1;
          end
          if (out_if.reply_code !== want.code) begin
            $display("%0t: reply_code mismatch, expected 0x%02h actual 0x%02h",
                     $time, want.code, out_if.reply_code);
            run_failed = 1'b1;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stim_proc
    fault_e      fault;
    bit          use_auth;
    logic [7:0]  bad;
    int unsigned useful;
    int unsigned before_len;
    int unsigned n_addr;
    int unsigned n_tail;

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.func     = FuncStart;
    in_if.rx_byte  = '0;
    out_if.ready   = 1'b0;

    // directed: stray byte before any start, auth path with empty domain,
    // byte after done, auth failure, bad hello version, bad method
    pending_bytes.push_back(data_byte(8'hFF));
    pending_bytes.push_back('{func: FuncStart, rx_byte: 8'hFF});
    pending_bytes.push_back(data_byte(SocksVersion));
    pending_bytes.push_back(data_byte(MethodUser));
    pending_bytes.push_back(data_byte(8'hFF));
    pending_bytes.push_back(data_byte(8'h00));
    pending_bytes.push_back(data_byte(SocksVersion));
    pending_bytes.push_back(data_byte(8'h00));
    pending_bytes.push_back(data_byte(8'hFF));
    pending_bytes.push_back(data_byte(AtypDomain));
    pending_bytes.push_back(data_byte(8'h00));
    pending_bytes.push_back(data_byte(8'h00));
    pending_bytes.push_back(data_byte(8'hFF));
    pending_bytes.push_back(data_byte(SocksVersion));
    pending_bytes.push_back('{func: FuncStart, rx_byte: 8'h00});
    pending_bytes.push_back(data_byte(SocksVersion));
    pending_bytes.push_back(data_byte(MethodUser));
    pending_bytes.push_back(data_byte(8'h01));
    pending_bytes.push_back(data_byte(8'hFF));
    pending_bytes.push_back(start_item());
    pending_bytes.push_back(data_byte(8'h00));
    pending_bytes.push_back(start_item());
    pending_bytes.push_back(data_byte(SocksVersion));
    pending_bytes.push_back(data_byte(8'hFF));

    // random: mostly well-formed handshakes with random content, some broken
    // at one field, some cut short and restarted mid-way
    useful = 0;
    while (useful < RandomBytes) begin
      // a little line noise between handshakes
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          pending_bytes.push_back('{func: 1'($urandom_range(0, 1)), rx_byte: 8'($urandom)});
        end
      end
      before_len = pending_bytes.size();
      fault      = ($urandom_range(0, 3) == 0) ? fault_e'($urandom_range(1, 7)) : F_NONE;
      use_auth   = 1'($urandom_range(0, 1));
      pending_bytes.push_back(start_item());

      if (fault == F_HELLO_VER) begin
        pending_bytes.push_back(data_byte(SocksVersion ^ 8'($urandom_range(1, 255))));
      end else begin
        pending_bytes.push_back(data_byte(SocksVersion));
        if (fault == F_METHOD) begin
          do bad = 8'($urandom); while (bad == MethodNoAuth || bad == MethodUser);
          pending_bytes.push_back(data_byte(bad));
        end else if (use_auth && fault == F_AUTH) begin
          pending_bytes.push_back(data_byte(MethodUser));
          pending_bytes.push_back(data_byte(8'($urandom)));
          pending_bytes.push_back(data_byte(8'($urandom_range(1, 255))));
        end else begin
          if (use_auth) begin
            pending_bytes.push_back(data_byte(MethodUser));
            pending_bytes.push_back(data_byte(8'($urandom)));
            pending_bytes.push_back(data_byte(8'h00));
          end else begin
            pending_bytes.push_back(data_byte(MethodNoAuth));
          end
          // connect reply
          if (fault == F_REP_VER) begin
            pending_bytes.push_back(data_byte(SocksVersion ^ 8'($urandom_range(1, 255))));
          end else begin
            pending_bytes.push_back(data_byte(SocksVersion));
            if (fault == F_REP_CODE) begin
              pending_bytes.push_back(data_byte(8'($urandom_range(1, 255))));
            end else begin
              pending_bytes.push_back(data_byte(8'h00));
              pending_bytes.push_back(data_byte(8'($urandom)));
              if (fault == F_ATYP) begin
                do bad = 8'($urandom);
                while (bad == AtypIpv4 || bad == AtypDomain || bad == AtypIpv6);
                pending_bytes.push_back(data_byte(bad));
              end else begin
                case ($urandom_range(0, 2))
                  0: begin
                    pending_bytes.push_back(data_byte(AtypIpv4));
                    n_addr = Ipv4Len;
                  end
                  1: begin
                    pending_bytes.push_back(data_byte(AtypIpv6));
                    n_addr = Ipv6Len;
                  end
                  default: begin
                    // mostly short names, now and then up to the longest
                    n_addr = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 12);
                    pending_bytes.push_back(data_byte(AtypDomain));
                    pending_bytes.push_back(data_byte(8'(n_addr)));
                  end
                endcase
                n_addr += PortLen;
                // a cut handshake stops somewhere inside address or port
                if (fault == F_CUT) n_addr = $urandom_range(0, n_addr - 1);
                repeat (n_addr) pending_bytes.push_back(data_byte(8'($urandom)));
              end
            end
          end
        end
      end
      useful += pending_bytes.size() - before_len;

      // bytes after done or an error are ignored and not counted
      if (fault != F_CUT && $urandom_range(0, 3) == 0) begin
        n_tail = $urandom_range(1, 2);
        repeat (n_tail) pending_bytes.push_back(data_byte(8'($urandom)));
      end
    end

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // all bytes handed over, then every reply back, then a quiet drain;
    // the first wait looks at the rising edge so the driver has settled
    while (pending_bytes.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (!run_failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
